### src/assert_macros.svh
// Assertion macros used by the block cipher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PYJ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PYJ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);
`else
`define PYJ_ASSERT(label, prop, msg)
`define PYJ_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### src/pyj_pkg.sv
// Shared types, constants and GF(2) helpers for the Pyjamask cipher.
package pyj_pkg;
	localparam int NUM_ROUNDS = 14;
	localparam int NUM_KEYS = NUM_ROUNDS + 1;
	localparam int KIDX_W = $clog2(NUM_KEYS);

	typedef logic [3:0][31:0] blk_t;
	typedef blk_t [NUM_KEYS-1:0] rk_arr_t;

	typedef struct packed {
		logic dec;
		logic wide;
		blk_t data;
	} item_t;

	localparam logic [1:0] REG_KEY_HIGH = 2'd0;
	localparam logic [1:0] REG_KEY_LOW = 2'd1;
	localparam logic [1:0] REG_WIDE_MODE = 2'd2;

	localparam logic [31:0] KS_MIX = 32'hb881b9ca;
	localparam logic [31:0] KS_C0 = 32'h00000080;
	localparam logic [31:0] KS_C1 = 32'h00006a00;
	localparam logic [31:0] KS_C2 = 32'h003f0000;
	localparam logic [31:0] KS_C3 = 32'h24000000;
	localparam logic [31:0] MIX_A = 32'ha3861085;
	localparam logic [31:0] MIX_B = 32'h63417021;
	localparam logic [31:0] MIX_C = 32'h692cf280;
	localparam logic [31:0] MIX_D = 32'h48a54813;
	localparam logic [31:0] IMIX_A = 32'h2037a121;
	localparam logic [31:0] IMIX_B = 32'h108ff2a0;
	localparam logic [31:0] IMIX_C = 32'h9054d8c0;
	localparam logic [31:0] IMIX_D = 32'h3354b117;

	// Circulant matrix with first row m times column v: bit 31-k of v picks m rotated right by k.
	function automatic logic [31:0] circ_mul(input logic [31:0] m, input logic [31:0] v);
		logic [31:0] acc;
		logic [63:0] mm;
		acc = '0;
		mm = {m, m};
		for (int k = 0; k < 32; k++) begin
			if (v[31-k]) acc = acc ^ mm[k +: 32];
		end
		return acc;
	endfunction
endpackage

### src/pyj_round.sv
// One cipher round, forward or inverse, with optional final key add.
module pyj_round (
	input  pyj_pkg::blk_t din,
	input  pyj_pkg::blk_t rkey,
	input  pyj_pkg::blk_t fkey,
	input  logic          dec,
	input  logic          wide,
	input  logic          last,
	output pyj_pkg::blk_t dout
);
	pyj_pkg::blk_t x;
	pyj_pkg::blk_t r;
	logic [31:0] a, b, c, d, t;

	always_comb begin
		x = din ^ rkey;
		if (!wide) x[3] = '0;
		r = '0;
		if (!dec) begin
			a = x[0]; b = x[1]; c = x[2]; d = x[3];
			if (wide) begin
				a = a ^ d;
				d = d ^ (a & b);
				a = a ^ (b & c);
				b = b ^ (c & d);
				c = c ^ (a & d);
				c = c ^ b;
				b = b ^ a;
				d = ~d;
				t = c; c = d; d = t;
				r[3] = pyj_pkg::circ_mul(pyj_pkg::MIX_D, d);
			end else begin
				t = '0;
				a = a ^ b;
				b = b ^ c;
				c = c ^ (a & b);
				a = a ^ (b & c);
				b = b ^ (a & c);
				c = c ^ a;
				c = ~c;
				b = b ^ a;
				a = a ^ b;
			end
			r[0] = pyj_pkg::circ_mul(pyj_pkg::MIX_A, a);
			r[1] = pyj_pkg::circ_mul(pyj_pkg::MIX_B, b);
			r[2] = pyj_pkg::circ_mul(pyj_pkg::MIX_C, c);
		end else begin
			a = pyj_pkg::circ_mul(pyj_pkg::IMIX_A, x[0]);
			b = pyj_pkg::circ_mul(pyj_pkg::IMIX_B, x[1]);
			c = pyj_pkg::circ_mul(pyj_pkg::IMIX_C, x[2]);
			if (wide) begin
				d = pyj_pkg::circ_mul(pyj_pkg::IMIX_D, x[3]);
				t = c; c = d; d = t;
				d = ~d;
				b = b ^ a;
				c = c ^ b;
				c = c ^ (a & d);
				b = b ^ (c & d);
				a = a ^ (b & c);
				d = d ^ (a & b);
				a = a ^ d;
			end else begin
				t = '0;
				d = '0;
				a = a ^ b;
				b = b ^ a;
				c = ~c;
				c = c ^ a;
				b = b ^ (a & c);
				a = a ^ (b & c);
				c = c ^ (a & b);
				b = b ^ c;
				a = a ^ b;
			end
			r = {d, c, b, a};
		end
		if (last) r = r ^ fkey;
		if (!wide) r[3] = '0;
		dout = r;
	end
endmodule

### src/pyj_keysched.sv
// Round key store and the sequencer that expands the key into it.
module pyj_keysched (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [127:0]     key,
	output logic             busy,
	output pyj_pkg::rk_arr_t rk
);
	logic                      busy_q;
	logic [pyj_pkg::KIDX_W-1:0] cnt_q;
	pyj_pkg::blk_t             kw_q;
	pyj_pkg::blk_t             kn;
	pyj_pkg::rk_arr_t          rk_q;
	logic [31:0]               tx;
	pyj_pkg::blk_t             km;
	logic [pyj_pkg::KIDX_W-1:0] rnd;

	always_comb begin
		rnd = cnt_q - 1'b1;
		tx = kw_q[0] ^ kw_q[1] ^ kw_q[2] ^ kw_q[3];
		for (int i = 0; i < 4; i++) km[i] = kw_q[i] ^ tx;
		kn[0] = pyj_pkg::circ_mul(pyj_pkg::KS_MIX, km[0]) ^ pyj_pkg::KS_C0 ^ 32'(rnd);
		kn[1] = {km[1][7:0], km[1][31:8]} ^ pyj_pkg::KS_C1;
		kn[2] = {km[2][14:0], km[2][31:15]} ^ pyj_pkg::KS_C2;
		kn[3] = {km[3][17:0], km[3][31:18]} ^ pyj_pkg::KS_C3;
	end

	// Start loads key 0, then one round key per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == pyj_pkg::KIDX_W'(pyj_pkg::NUM_ROUNDS)) busy_q <= 1'b0;
			else cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !start) begin
			if (cnt_q == '0) begin
				kw_q <= {key[31:0], key[63:32], key[95:64], key[127:96]};
				rk_q[0] <= {key[31:0], key[63:32], key[95:64], key[127:96]};
			end else begin
				kw_q <= kn;
				rk_q[cnt_q] <= kn;
			end
		end
	end

	assign busy = busy_q;
	assign rk = rk_q;
endmodule

### src/pyjamask_block_cipher.sv
// Pyjamask-128/96 block cipher, one round per pipeline stage.
// Throughput: one request per cycle while no key expansion runs; a stall at the output holds all stages.
// Reset clears the key to zero and selects the 128-bit mode, then expands round keys
// with in_stall high; every key write repeats that expansion.
`include "assert_macros.svh"
module pyjamask_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [31:0] in_word0,
	input  logic [31:0] in_word1,
	input  logic [31:0] in_word2,
	input  logic [31:0] in_word3,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_word0,
	output logic [31:0] out_word1,
	output logic [31:0] out_word2,
	output logic [31:0] out_word3
);
	localparam int NR = pyj_pkg::NUM_ROUNDS;

	logic [63:0] key_high_q, key_low_q;
	logic        wide_q;
	logic        ks_start, ks_busy;
	logic        advance;
	pyj_pkg::rk_arr_t rk;

	// Pipeline stage registers: index i holds the item after round i+1.
	logic          [NR-1:0] vld_s;
	pyj_pkg::item_t         pipe_s [NR];
	pyj_pkg::item_t         stg_in [NR];
	pyj_pkg::blk_t          stg_out [NR];

	// Configuration registers; a key write restarts expansion.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			wide_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pyj_pkg::REG_KEY_HIGH: key_high_q <= cfg_data;
				pyj_pkg::REG_KEY_LOW: key_low_q <= cfg_data;
				pyj_pkg::REG_WIDE_MODE: wide_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign ks_start = cfg_we && (cfg_index == pyj_pkg::REG_KEY_HIGH ||
		cfg_index == pyj_pkg::REG_KEY_LOW);

	pyj_keysched u_keysched (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ks_start),
		.key    ({key_high_q, key_low_q}),
		.busy   (ks_busy),
		.rk     (rk)
	);

	// Hold every stage while the result waits.
	assign advance = !out_valid || !out_stall;
	assign in_stall = !advance || ks_busy;

	// Drop word 3 of the request in the 96-bit mode.
	always_comb begin
		stg_in[0].dec = opcode;
		stg_in[0].wide = wide_q;
		stg_in[0].data = {wide_q ? in_word3 : 32'd0, in_word2, in_word1, in_word0};
		for (int i = 1; i < NR; i++) stg_in[i] = pipe_s[i-1];
	end

	for (genvar g = 0; g < NR; g++) begin : g_round
		// Encrypt uses key g, decrypt walks the keys downward from the last.
		pyj_round u_round (
			.din  (stg_in[g].data),
			.rkey (stg_in[g].dec ? rk[NR-g] : rk[g]),
			.fkey (stg_in[g].dec ? rk[0] : rk[NR]),
			.dec  (stg_in[g].dec),
			.wide (stg_in[g].wide),
			.last (g == NR-1),
			.dout (stg_out[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (advance) begin
			vld_s <= {vld_s[NR-2:0], in_valid && !in_stall};
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < NR; i++) begin
				pipe_s[i].dec <= stg_in[i].dec;
				pipe_s[i].wide <= stg_in[i].wide;
				pipe_s[i].data <= stg_out[i];
			end
		end
	end

	assign out_valid = vld_s[NR-1];
	assign out_word0 = pipe_s[NR-1].data[0];
	assign out_word1 = pipe_s[NR-1].data[1];
	assign out_word2 = pipe_s[NR-1].data[2];
	assign out_word3 = pipe_s[NR-1].data[3];

	`PYJ_ASSERT(a_no_accept_busy, ks_busy |-> in_stall, "request accepted during key expansion")
	`PYJ_ASSERT_NEXT(a_advance_last, advance && vld_s[NR-2], out_valid, "result lost in last stage")
	`PYJ_ASSERT_NEXT(a_hold_stall, !advance && vld_s[0], vld_s[0], "stage valid dropped in stall")
endmodule

### tb/tb.sv
// Testbench for the Pyjamask block cipher: predicts results and checks them against the DUT.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Register index that the block has no register behind.
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 30;

	typedef struct packed {
		logic op;
		pyj_pkg::blk_t words;
	} request_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        opcode;
	logic [31:0] in_word0, in_word1, in_word2, in_word3;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] out_word0, out_word1, out_word2, out_word3;

	pyjamask_block_cipher DUT (.*);

	// Predictor state: its own copy of the key registers, mode and round keys.
	logic [63:0]   key_hi_copy, key_lo_copy;
	logic          wide_copy;
	pyj_pkg::blk_t round_keys [pyj_pkg::NUM_KEYS];

	request_t      pending_requests[$];
	pyj_pkg::blk_t expected_blocks[$];
	request_t      req_now;

	int send_idle_pct, recv_stall_pct;
	int mismatches = 0;
	int idle_cycles;
	int enc_count = 0;
	int dec_count = 0;
	int narrow_count = 0;
	int result_count = 0;

	function automatic logic [31:0] rot_right(logic [31:0] v, int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	// Circulant GF(2) product: bit 31 of v picks row m, each lower bit the next right rotation.
	function automatic logic [31:0] gf2_circ(logic [31:0] m, logic [31:0] v);
		logic [31:0] acc;
		acc = '0;
		for (int b = 31; b >= 0; b--) begin
			if (v[b]) acc ^= m;
			m = rot_right(m, 1);
		end
		return acc;
	endfunction

	function automatic void expand_round_keys();
		logic [31:0] w0, w1, w2, w3, t;
		w0 = key_hi_copy[63:32];
		w1 = key_hi_copy[31:0];
		w2 = key_lo_copy[63:32];
		w3 = key_lo_copy[31:0];
		round_keys[0] = {w3, w2, w1, w0};
		for (int r = 0; r < pyj_pkg::NUM_ROUNDS; r++) begin
			t = w0 ^ w1 ^ w2 ^ w3;
			w0 ^= t; w1 ^= t; w2 ^= t; w3 ^= t;
			w0 = gf2_circ(pyj_pkg::KS_MIX, w0) ^ pyj_pkg::KS_C0 ^ 32'(r);
			w1 = rot_right(w1, 8) ^ pyj_pkg::KS_C1;
			w2 = rot_right(w2, 15) ^ pyj_pkg::KS_C2;
			w3 = rot_right(w3, 18) ^ pyj_pkg::KS_C3;
			round_keys[r+1] = {w3, w2, w1, w0};
		end
	endfunction

	function automatic pyj_pkg::blk_t add_round_key(pyj_pkg::blk_t s, int idx, logic wide);
		for (int i = 0; i < 3; i++) s[i] ^= round_keys[idx][i];
		if (wide) s[3] ^= round_keys[idx][3];
		return s;
	endfunction

	function automatic pyj_pkg::blk_t cipher_block(request_t rq, logic wide);
		pyj_pkg::blk_t s;
		logic [31:0] a, b, c, d, t;
		s = rq.words;
		if (!wide) s[3] = '0;
		if (!rq.op) begin
			for (int r = 0; r < pyj_pkg::NUM_ROUNDS; r++) begin
				s = add_round_key(s, r, wide);
				a = s[0]; b = s[1]; c = s[2]; d = s[3];
				if (wide) begin
					a ^= d; d ^= a & b; a ^= b & c; b ^= c & d;
					c ^= a & d; c ^= b; b ^= a; d = ~d;
					t = c; c = d; d = t;
					s[3] = gf2_circ(pyj_pkg::MIX_D, d);
				end else begin
					a ^= b; b ^= c; c ^= a & b; a ^= b & c; b ^= a & c;
					c ^= a; c = ~c; b ^= a; a ^= b;
					s[3] = '0;
				end
				s[0] = gf2_circ(pyj_pkg::MIX_A, a);
				s[1] = gf2_circ(pyj_pkg::MIX_B, b);
				s[2] = gf2_circ(pyj_pkg::MIX_C, c);
			end
			s = add_round_key(s, pyj_pkg::NUM_ROUNDS, wide);
		end else begin
			s = add_round_key(s, pyj_pkg::NUM_ROUNDS, wide);
			for (int r = pyj_pkg::NUM_ROUNDS; r > 0; r--) begin
				a = gf2_circ(pyj_pkg::IMIX_A, s[0]);
				b = gf2_circ(pyj_pkg::IMIX_B, s[1]);
				c = gf2_circ(pyj_pkg::IMIX_C, s[2]);
				if (wide) begin
					d = gf2_circ(pyj_pkg::IMIX_D, s[3]);
					t = c; c = d; d = t;
					d = ~d; b ^= a; c ^= b; c ^= a & d;
					b ^= c & d; a ^= b & c; d ^= a & b; a ^= d;
				end else begin
					d = '0;
					a ^= b; b ^= a; c = ~c; c ^= a; b ^= a & c;
					a ^= b & c; c ^= a & b; b ^= c; a ^= b;
				end
				s = {d, c, b, a};
				s = add_round_key(s, r - 1, wide);
			end
		end
		if (!wide) s[3] = '0;
		return s;
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Driver: present queued requests, hold a request while it is stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode   <= 1'b0;
			in_word0 <= '0;
			in_word1 <= '0;
			in_word2 <= '0;
			in_word3 <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_blocks.push_back(cipher_block(req_now, wide_copy));
				if (req_now.op) dec_count++; else enc_count++;
				if (!wide_copy) narrow_count++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_requests.size() > 0 &&
						$urandom_range(99) >= send_idle_pct) begin
					req_now = pending_requests.pop_front();
					in_valid <= 1'b1;
					opcode   <= req_now.op;
					in_word0 <= req_now.words[0];
					in_word1 <= req_now.words[1];
					in_word2 <= req_now.words[2];
					in_word3 <= req_now.words[3];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall at random, compare each accepted result with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				result_count++;
				if (expected_blocks.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result expected none actual %h %h %h %h",
						$time, out_word0, out_word1, out_word2, out_word3);
				end else begin
					pyj_pkg::blk_t want;
					want = expected_blocks.pop_front();
					if ({out_word3, out_word2, out_word1, out_word0} !== want) begin
						mismatches++;
						$display("%0t: result mismatch expected %h %h %h %h actual %h %h %h %h",
							$time, want[0], want[1], want[2], want[3],
							out_word0, out_word1, out_word2, out_word3);
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog: end the run if no request, result or register write moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [63:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			pyj_pkg::REG_KEY_HIGH: begin
				key_hi_copy = value;
				expand_round_keys();
			end
			pyj_pkg::REG_KEY_LOW: begin
				key_lo_copy = value;
				expand_round_keys();
			end
			pyj_pkg::REG_WIDE_MODE: wide_copy = value[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_request(logic op, pyj_pkg::blk_t words);
		request_t rq;
		rq.op = op;
		rq.words = words;
		pending_requests.push_back(rq);
	endtask

	// Drain: wait until every request is sent and every result has come back.
	// Sample at the falling edge so the driver and monitor updates have settled.
	task automatic drain();
		do @(negedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_blocks.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 32'h1 << $urandom_range(31);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [63:0] rand_key();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	initial begin
		pyj_pkg::blk_t ct;
		request_t probe;
		cfg_we = 1'b0;
		cfg_index = pyj_pkg::REG_KEY_HIGH;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		key_hi_copy = '0;
		key_lo_copy = '0;
		wide_copy = 1'b1;
		expand_round_keys();
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset key, extremes of the block in both directions and modes.
		for (int m = 0; m < 2; m++) begin
			if (m == 1) write_reg(pyj_pkg::REG_WIDE_MODE, 64'd0);
			for (int op = 0; op < 2; op++) begin
				queue_request(op[0], '0);
				queue_request(op[0], '1);
				queue_request(op[0], {32'h0, 32'hffffffff, 32'h0, 32'hffffffff});
				queue_request(op[0], {$urandom, $urandom, $urandom, $urandom});
			end
			drain();
		end
		// Extreme keys, a stray write to the unused index, and encrypt-then-decrypt pairs.
		write_reg(pyj_pkg::REG_KEY_HIGH, '1);
		write_reg(pyj_pkg::REG_KEY_LOW, '1);
		write_reg(REG_UNUSED, {$urandom, $urandom});
		write_reg(pyj_pkg::REG_WIDE_MODE, 64'd1);
		for (int m = 0; m < 2; m++) begin
			probe.op = 1'b0;
			probe.words = {$urandom, $urandom, $urandom, $urandom};
			queue_request(1'b0, probe.words);
			ct = cipher_block(probe, wide_copy);
			queue_request(1'b1, ct);
			queue_request(1'b1, '1);
			drain();
			write_reg(pyj_pkg::REG_WIDE_MODE, 64'd0);
		end

		// Random phases: sweep idling patterns and key/mode settings.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
				default: begin send_idle_pct = 20; recv_stall_pct = 20; end
			endcase
			write_reg(pyj_pkg::REG_KEY_HIGH, (ph == 7) ? 64'd0 : rand_key());
			write_reg(pyj_pkg::REG_KEY_LOW, (ph == 7) ? '1 : rand_key());
			write_reg(pyj_pkg::REG_WIDE_MODE, {63'd0, ph[0]});
			for (int i = 0; i < 250; i++) begin
				if ($urandom_range(3) == 0) begin
					probe.op = 1'b0;
					probe.words = {rand_word(), rand_word(), rand_word(), rand_word()};
					queue_request(1'b0, probe.words);
					queue_request(1'b1, cipher_block(probe, wide_copy));
					i++;
				end else begin
					queue_request(1'($urandom_range(1)),
						{rand_word(), rand_word(), rand_word(), rand_word()});
				end
			end
			drain();
		end

		$display("Covered %0d encrypt and %0d decrypt blocks (%0d in 96-bit mode), %0d results",
			enc_count, dec_count, narrow_count, result_count);
		$display("across several keys and idle/stall mixes; mismatches: %0d", mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
